[rtl/core/spherical_to_cartesian_assert.svh]
// assertion macros used by the checker file
`ifndef SPHERICAL_TO_CARTESIAN_ASSERT_SVH
`define SPHERICAL_TO_CARTESIAN_ASSERT_SVH

// clocked assertion, ignored while reset is held
`define S2C_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also covers the reset cycles
`define S2C_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/s2c_pkg.sv]
package s2c_pkg;

    localparam int ANG_W = 16;
    localparam int RAD_W = 24;
    localparam int OUT_W = 25;
    // cordic datapath, q2.30 with headroom
    localparam int CW = 34;
    // trig values after quadrant mapping, q2.30
    localparam int TW = 32;
    // radius times trig value after rounding
    localparam int PW = 27;
    localparam int PI_W = 31;
    localparam int ATAN_N = 24;

    localparam logic signed [PI_W-1:0] PI_Q28 = 31'sd843314857;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [OUT_W-1:0] OUT_MAX = 25'sd16777215;
    localparam logic [ANG_W-1:0] EIGHTH_TURN = 16'h2000;

    localparam logic signed [CW-1:0] ATAN_Q30 [ATAN_N] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686, 34'sd33543515, 34'sd16775850, 34'sd8388437,
        34'sd4194282, 34'sd2097149, 34'sd1048575, 34'sd524287,
        34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767,
        34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
        34'sd1023, 34'sd511, 34'sd255, 34'sd127
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // pipeline advance and valid of the item entering a section
    typedef struct packed {
        logic en;
        logic vld;
    } t_flow;

endpackage

[rtl/core/s2c_if.sv]
interface s2c_in_if;
    import s2c_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [ANG_W-1:0] ring_fraction;
    logic [ANG_W-1:0]        sector_fraction;
    logic [RAD_W-1:0]        radius;

    modport source (output valid, ring_fraction, sector_fraction, radius, input ready);
    modport sink (input valid, ring_fraction, sector_fraction, radius, output ready);
endinterface

interface s2c_out_if;
    import s2c_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] x_coord;
    logic signed [OUT_W-1:0] y_coord;
    logic signed [OUT_W-1:0] z_coord;

    modport source (output valid, x_coord, y_coord, z_coord, input ready);
    modport sink (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

[rtl/core/s2c_angle.sv]
module s2c_angle (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  s2c_pkg::t_flow                i_flow,
    input  logic [s2c_pkg::ANG_W-1:0]     i_ring,
    input  logic [s2c_pkg::ANG_W-1:0]     i_sector,
    input  logic [s2c_pkg::RAD_W-1:0]     i_radius,
    output logic                          o_vld,
    output logic [1:0]                    o_quad_lat,
    output logic [1:0]                    o_quad_lon,
    output logic signed [s2c_pkg::CW-1:0] o_z_lat,
    output logic signed [s2c_pkg::CW-1:0] o_z_lon,
    output logic [s2c_pkg::RAD_W-1:0]     o_radius
);
    import s2c_pkg::*;

    localparam int RES_W = ANG_W - 2;
    localparam int MUL_W = RES_W + PI_W;

    // residual of the nearest quarter turn, turned into radians q2.30
    function automatic logic signed [CW-1:0] resid_rad(input logic [ANG_W-1:0] a);
        logic [ANG_W-1:0]        sh;
        logic signed [RES_W-1:0] res;
        logic signed [MUL_W-1:0] prod;
        sh   = a + EIGHTH_TURN;
        res  = $signed({~sh[RES_W-1], sh[RES_W-2:0]});
        prod = MUL_W'(res) * MUL_W'(PI_Q28) + MUL_W'(4096);
        return CW'($signed(prod[MUL_W-1:13]));
    endfunction

    logic [ANG_W-1:0] lat_sh;
    logic [ANG_W-1:0] lon_sh;
    logic             r_vld;

    assign lat_sh = i_ring + EIGHTH_TURN;
    assign lon_sh = i_sector + EIGHTH_TURN;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_flow.en) begin
            r_vld <= i_flow.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            o_quad_lat <= lat_sh[ANG_W-1:ANG_W-2];
            o_quad_lon <= lon_sh[ANG_W-1:ANG_W-2];
            o_z_lat    <= resid_rad(i_ring);
            o_z_lon    <= resid_rad(i_sector);
            o_radius   <= i_radius;
        end
    end

    assign o_vld = r_vld;

endmodule

[rtl/core/s2c_cordic.sv]
module s2c_cordic #(
    parameter int STAGES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  s2c_pkg::t_flow                i_flow,
    input  logic [1:0]                    i_quad_lat,
    input  logic [1:0]                    i_quad_lon,
    input  logic signed [s2c_pkg::CW-1:0] i_z_lat,
    input  logic signed [s2c_pkg::CW-1:0] i_z_lon,
    input  logic [s2c_pkg::RAD_W-1:0]     i_radius,
    output logic                          o_vld,
    output logic [1:0]                    o_quad_lat,
    output logic [1:0]                    o_quad_lon,
    output logic signed [s2c_pkg::CW-1:0] o_x_lat,
    output logic signed [s2c_pkg::CW-1:0] o_y_lat,
    output logic signed [s2c_pkg::CW-1:0] o_x_lon,
    output logic signed [s2c_pkg::CW-1:0] o_y_lon,
    output logic [s2c_pkg::RAD_W-1:0]     o_radius
);
    import s2c_pkg::*;

    // lane 0 is latitude, lane 1 is longitude
    logic signed [CW-1:0] r_x   [STAGES][2];
    logic signed [CW-1:0] r_y   [STAGES][2];
    logic signed [CW-1:0] r_z   [STAGES][2];
    logic [1:0]           r_qa  [STAGES];
    logic [1:0]           r_qo  [STAGES];
    logic [RAD_W-1:0]     r_rad [STAGES];
    logic                 r_vld [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stg
        logic signed [CW-1:0] x_in [2];
        logic signed [CW-1:0] y_in [2];
        logic signed [CW-1:0] z_in [2];
        logic [1:0]           qa_in;
        logic [1:0]           qo_in;
        logic [RAD_W-1:0]     rad_in;
        logic                 vld_in;

        if (k == 0) begin : g_first
            assign x_in[0] = GAIN_Q30;
            assign x_in[1] = GAIN_Q30;
            assign y_in[0] = '0;
            assign y_in[1] = '0;
            assign z_in[0] = i_z_lat;
            assign z_in[1] = i_z_lon;
            assign qa_in   = i_quad_lat;
            assign qo_in   = i_quad_lon;
            assign rad_in  = i_radius;
            assign vld_in  = i_flow.vld;
        end else begin : g_next
            assign x_in   = r_x[k-1];
            assign y_in   = r_y[k-1];
            assign z_in   = r_z[k-1];
            assign qa_in  = r_qa[k-1];
            assign qo_in  = r_qo[k-1];
            assign rad_in = r_rad[k-1];
            assign vld_in = r_vld[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_flow.en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_flow.en) begin
                r_qa[k]  <= qa_in;
                r_qo[k]  <= qo_in;
                r_rad[k] <= rad_in;
                for (int l = 0; l < 2; l++) begin
                    // rotate toward zero residual angle
                    if (!z_in[l][CW-1]) begin
                        r_x[k][l] <= x_in[l] - (y_in[l] >>> k);
                        r_y[k][l] <= y_in[l] + (x_in[l] >>> k);
                        r_z[k][l] <= z_in[l] - ATAN_Q30[k];
                    end else begin
                        r_x[k][l] <= x_in[l] + (y_in[l] >>> k);
                        r_y[k][l] <= y_in[l] - (x_in[l] >>> k);
                        r_z[k][l] <= z_in[l] + ATAN_Q30[k];
                    end
                end
            end
        end
    end

    assign o_vld      = r_vld[STAGES-1];
    assign o_quad_lat = r_qa[STAGES-1];
    assign o_quad_lon = r_qo[STAGES-1];
    assign o_x_lat    = r_x[STAGES-1][0];
    assign o_y_lat    = r_y[STAGES-1][0];
    assign o_x_lon    = r_x[STAGES-1][1];
    assign o_y_lon    = r_y[STAGES-1][1];
    assign o_radius   = r_rad[STAGES-1];

endmodule

[rtl/core/s2c_scale.sv]
module s2c_scale (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  s2c_pkg::t_flow                   i_flow,
    input  logic [1:0]                       i_quad_lat,
    input  logic [1:0]                       i_quad_lon,
    input  logic signed [s2c_pkg::CW-1:0]    i_x_lat,
    input  logic signed [s2c_pkg::CW-1:0]    i_y_lat,
    input  logic signed [s2c_pkg::CW-1:0]    i_x_lon,
    input  logic signed [s2c_pkg::CW-1:0]    i_y_lon,
    input  logic [s2c_pkg::RAD_W-1:0]        i_radius,
    output logic                             o_vld,
    output logic signed [s2c_pkg::OUT_W-1:0] o_x,
    output logic signed [s2c_pkg::OUT_W-1:0] o_y,
    output logic signed [s2c_pkg::OUT_W-1:0] o_z
);
    import s2c_pkg::*;

    localparam int TT_W = 2 * TW;
    localparam int RT_W = RAD_W + 1 + TW;
    localparam int SW   = PW + 1;

    // quadrant mapping, result packed as {sin, cos}
    function automatic logic [2*TW-1:0] quad_map(
        input logic [1:0]           q,
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y
    );
        logic signed [CW-1:0] s;
        logic signed [CW-1:0] c;
        case (q)
            QUAD_0: begin
                s = y;
                c = x;
            end
            QUAD_1: begin
                s = x;
                c = -y;
            end
            QUAD_2: begin
                s = -y;
                c = -x;
            end
            default: begin
                s = -x;
                c = y;
            end
        endcase
        return {s[TW-1:0], c[TW-1:0]};
    endfunction

    function automatic logic signed [TW-1:0] mul_q30(
        input logic signed [TW-1:0] a,
        input logic signed [TW-1:0] b
    );
        logic signed [TT_W-1:0] p;
        p = TT_W'(a) * TT_W'(b) + (TT_W'(1) <<< 29);
        return p[TW+29:30];
    endfunction

    function automatic logic signed [PW-1:0] mul_rad(
        input logic [RAD_W-1:0]     r,
        input logic signed [TW-1:0] t
    );
        logic signed [RT_W-1:0] p;
        p = RT_W'($signed({1'b0, r})) * RT_W'(t) + (RT_W'(1) <<< 29);
        return p[RT_W-1:30];
    endfunction

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [SW-1:0] v);
        if (v > SW'(OUT_MAX)) begin
            return OUT_MAX;
        end else if (v < -SW'(OUT_MAX)) begin
            return -OUT_MAX;
        end
        return v[OUT_W-1:0];
    endfunction

    logic [2*TW-1:0] lat_sc;
    logic [2*TW-1:0] lon_sc;

    // stage a: quadrant mapping
    logic                 r_a_vld;
    logic signed [TW-1:0] r_a_s_lat;
    logic signed [TW-1:0] r_a_c_lat;
    logic signed [TW-1:0] r_a_s_lon;
    logic signed [TW-1:0] r_a_c_lon;
    logic [RAD_W-1:0]     r_a_rad;
    // stage b: trig products
    logic                 r_b_vld;
    logic signed [TW-1:0] r_b_tx;
    logic signed [TW-1:0] r_b_ty;
    logic signed [TW-1:0] r_b_tz;
    logic [RAD_W-1:0]     r_b_rad;
    // stage c: radius products
    logic                 r_c_vld;
    logic signed [PW-1:0] r_c_px;
    logic signed [PW-1:0] r_c_py;
    logic signed [PW-1:0] r_c_pz;
    // stage d: saturation
    logic                 r_d_vld;

    assign lat_sc = quad_map(i_quad_lat, i_x_lat, i_y_lat);
    assign lon_sc = quad_map(i_quad_lon, i_x_lon, i_y_lon);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else if (i_flow.en) begin
            r_a_vld <= i_flow.vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.en) begin
            r_a_s_lat <= lat_sc[2*TW-1:TW];
            r_a_c_lat <= lat_sc[TW-1:0];
            r_a_s_lon <= lon_sc[2*TW-1:TW];
            r_a_c_lon <= lon_sc[TW-1:0];
            r_a_rad   <= i_radius;

            r_b_tx  <= mul_q30(r_a_c_lon, r_a_c_lat);
            r_b_ty  <= mul_q30(r_a_s_lon, r_a_c_lat);
            r_b_tz  <= r_a_s_lat;
            r_b_rad <= r_a_rad;

            r_c_px <= mul_rad(r_b_rad, r_b_tx);
            r_c_py <= mul_rad(r_b_rad, r_b_ty);
            r_c_pz <= mul_rad(r_b_rad, r_b_tz);

            o_x <= sat(SW'(r_c_px));
            o_y <= sat(-SW'(r_c_py));
            o_z <= sat(SW'(r_c_pz));
        end
    end

    assign o_vld = r_d_vld;

endmodule

[rtl/core/spherical_to_cartesian.sv]
// channel   dir  fields                                      transaction
// i_pt      in   ring_fraction, sector_fraction, radius      one point
// o_xyz     out  x_coord, y_coord, z_coord                   one cartesian result
//
// one point per cycle while the skid register below is free; the pipeline is the cordic stage chain
// plus the angle, quadrant, two multiply and saturation stages
// synchronous active-low reset clears all valid bits; no clearing pass
// an output skid register holds one result, so o_xyz.ready low stalls the
// pipeline only once that register is full; i_pt.ready comes from a flop
module spherical_to_cartesian #(
    parameter int CORDIC_STAGES = 16
) (
    input logic    i_clk,
    input logic    i_rst_n,
    s2c_in_if.sink   i_pt,
    s2c_out_if.source o_xyz
);
    import s2c_pkg::*;

    t_flow                ang_flow;
    t_flow                cor_flow;
    t_flow                scl_flow;
    logic                 en;

    logic                 ang_vld;
    logic [1:0]           ang_qa;
    logic [1:0]           ang_qo;
    logic signed [CW-1:0] ang_za;
    logic signed [CW-1:0] ang_zo;
    logic [RAD_W-1:0]     ang_rad;

    logic                 cor_vld;
    logic [1:0]           cor_qa;
    logic [1:0]           cor_qo;
    logic signed [CW-1:0] cor_xa;
    logic signed [CW-1:0] cor_ya;
    logic signed [CW-1:0] cor_xo;
    logic signed [CW-1:0] cor_yo;
    logic [RAD_W-1:0]     cor_rad;

    logic                    scl_vld;
    logic signed [OUT_W-1:0] scl_x;
    logic signed [OUT_W-1:0] scl_y;
    logic signed [OUT_W-1:0] scl_z;

    logic                    r_skid_vld;
    logic                    n_skid_vld;
    logic signed [OUT_W-1:0] r_skid_x;
    logic signed [OUT_W-1:0] r_skid_y;
    logic signed [OUT_W-1:0] r_skid_z;

    // pipeline moves whenever the skid register is free
    assign en         = !r_skid_vld;
    assign i_pt.ready = en;

    assign ang_flow = '{en: en, vld: i_pt.valid};
    assign cor_flow = '{en: en, vld: ang_vld};
    assign scl_flow = '{en: en, vld: cor_vld};

    s2c_angle u_angle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flow     (ang_flow),
        .i_ring     (i_pt.ring_fraction),
        .i_sector   (i_pt.sector_fraction),
        .i_radius   (i_pt.radius),
        .o_vld      (ang_vld),
        .o_quad_lat (ang_qa),
        .o_quad_lon (ang_qo),
        .o_z_lat    (ang_za),
        .o_z_lon    (ang_zo),
        .o_radius   (ang_rad)
    );

    s2c_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flow     (cor_flow),
        .i_quad_lat (ang_qa),
        .i_quad_lon (ang_qo),
        .i_z_lat    (ang_za),
        .i_z_lon    (ang_zo),
        .i_radius   (ang_rad),
        .o_vld      (cor_vld),
        .o_quad_lat (cor_qa),
        .o_quad_lon (cor_qo),
        .o_x_lat    (cor_xa),
        .o_y_lat    (cor_ya),
        .o_x_lon    (cor_xo),
        .o_y_lon    (cor_yo),
        .o_radius   (cor_rad)
    );

    s2c_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_flow     (scl_flow),
        .i_quad_lat (cor_qa),
        .i_quad_lon (cor_qo),
        .i_x_lat    (cor_xa),
        .i_y_lat    (cor_ya),
        .i_x_lon    (cor_xo),
        .i_y_lon    (cor_yo),
        .i_radius   (cor_rad),
        .o_vld      (scl_vld),
        .o_x        (scl_x),
        .o_y        (scl_y),
        .o_z        (scl_z)
    );

    always_comb begin
        n_skid_vld = r_skid_vld;
        if (r_skid_vld) begin
            if (o_xyz.ready) begin
                n_skid_vld = 1'b0;
            end
        end else if (scl_vld && !o_xyz.ready) begin
            n_skid_vld = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else begin
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_skid_x <= scl_x;
            r_skid_y <= scl_y;
            r_skid_z <= scl_z;
        end
    end

    assign o_xyz.valid   = r_skid_vld || scl_vld;
    assign o_xyz.x_coord = r_skid_vld ? r_skid_x : scl_x;
    assign o_xyz.y_coord = r_skid_vld ? r_skid_y : scl_y;
    assign o_xyz.z_coord = r_skid_vld ? r_skid_z : scl_z;

endmodule

[rtl/core/s2c_check.sv]
`include "spherical_to_cartesian_assert.svh"

module s2c_check (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             i_in_ready,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic signed [s2c_pkg::OUT_W-1:0] i_x,
    input logic signed [s2c_pkg::OUT_W-1:0] i_y,
    input logic signed [s2c_pkg::OUT_W-1:0] i_z
);
    import s2c_pkg::*;

    logic signed [OUT_W-1:0] neg_full;

    // the most negative code lies outside the saturation range
    assign neg_full = {1'b1, {(OUT_W-1){1'b0}}};

    `S2C_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_x) && $stable(i_y) && $stable(i_z)), "output transaction changed while stalled")
    `S2C_ASSERT(a_sat_range, i_clk, i_rst_n, i_out_valid |-> (i_x != neg_full && i_y != neg_full && i_z != neg_full), "output outside saturation range")
    `S2C_ASSERT(a_busy_has_out, i_clk, i_rst_n, (!i_in_ready && i_in_valid) |-> i_out_valid, "input held off with no result waiting")
    `S2C_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid, "result shown right after reset")

endmodule

bind spherical_to_cartesian s2c_check u_s2c_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_out_valid (o_xyz.valid),
    .i_out_ready (o_xyz.ready),
    .i_x         (o_xyz.x_coord),
    .i_y         (o_xyz.y_coord),
    .i_z         (o_xyz.z_coord)
);

[sim/spherical_to_cartesian_tb.sv]
module spherical_to_cartesian_tb;
    import s2c_pkg::*;

    localparam int STAGES = 16;
    localparam int PIPE_LATENCY = STAGES + 5;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PER_PHASE = 467;

    localparam longint PI_Q28_L = 64'sd843314857;
    localparam longint GAIN_Q30_L = 64'sd652032874;
    localparam longint COORD_MAX = 64'sd16777215;
    localparam logic [ANG_W-1:0] EIGHTH = 16'h2000;
    localparam logic [ANG_W-1:0] QUARTER = 16'h4000;
    localparam logic [RAD_W-1:0] RADIUS_MAX = 24'hFFFFFF;

    localparam longint ARCTAN_Q30 [24] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686, 64'sd33543515, 64'sd16775850, 64'sd8388437,
        64'sd4194282, 64'sd2097149, 64'sd1048575, 64'sd524287,
        64'sd262143, 64'sd131071, 64'sd65535, 64'sd32767,
        64'sd16383, 64'sd8191, 64'sd4095, 64'sd2047,
        64'sd1023, 64'sd511, 64'sd255, 64'sd127
    };

    typedef struct packed {
        logic signed [ANG_W-1:0] ring;
        logic [ANG_W-1:0]        sector;
        logic [RAD_W-1:0]        radius;
    } t_point;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } t_xyz;

    logic i_clk;
    logic i_rst_n;

    s2c_in_if  pt_if ();
    s2c_out_if xyz_if ();

    spherical_to_cartesian #(
        .CORDIC_STAGES(STAGES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_pt(pt_if),
        .o_xyz(xyz_if)
    );

    t_point      pending_points[$];
    t_xyz        expected_xyz[$];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned points_sent;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned stall_cycles;

    // sine and cosine in q2.30 of a 16-bit binary angle
    function automatic void angle_sincos(input logic [ANG_W-1:0] ang,
                                         output longint s, output longint c);
        logic [ANG_W-1:0] shifted;
        logic [1:0]       quad;
        longint           res, z, x, y, dx, dy;
        int               n;
        shifted = ang + EIGHTH;
        quad = shifted[15:14];
        res = longint'(shifted[13:0]) - longint'(EIGHTH);
        z = (res * PI_Q28_L + 64'sd4096) >>> 13;
        x = GAIN_Q30_L;
        y = 0;
        n = (STAGES > 24) ? 24 : STAGES;
        for (int i = 0; i < n; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ARCTAN_Q30[i];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ARCTAN_Q30[i];
            end
        end
        case (quad)
            QUAD_0: begin s = y;  c = x;  end
            QUAD_1: begin s = x;  c = -y; end
            QUAD_2: begin s = -y; c = -x; end
            default: begin s = -x; c = y; end
        endcase
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic longint clip_coord(longint v);
        if (v > COORD_MAX) return COORD_MAX;
        if (v < -COORD_MAX) return -COORD_MAX;
        return v;
    endfunction

    function automatic t_xyz predict_xyz(t_point p);
        longint s_lat, c_lat, s_lon, c_lon, r, x, y, z;
        t_xyz   res;
        angle_sincos(p.ring, s_lat, c_lat);
        angle_sincos(p.sector, s_lon, c_lon);
        r = longint'(p.radius);
        z = clip_coord(q30_mul(r, s_lat));
        x = clip_coord(q30_mul(r, q30_mul(c_lon, c_lat)));
        y = clip_coord(-q30_mul(r, q30_mul(s_lon, c_lat)));
        res.x = x[OUT_W-1:0];
        res.y = y[OUT_W-1:0];
        res.z = z[OUT_W-1:0];
        return res;
    endfunction

    // angle close to a quadrant split or a quarter-turn multiple
    function automatic logic [ANG_W-1:0] angle_near_split();
        logic [ANG_W-1:0] base;
        base = ANG_W'(QUARTER * $urandom_range(3));
        if ($urandom_range(1))
            base = base + EIGHTH;
        return ANG_W'(base + $urandom_range(8) - 4);
    endfunction

    function automatic t_point random_point();
        t_point p;
        p.ring = ANG_W'($urandom);
        p.sector = ANG_W'($urandom);
        p.radius = RAD_W'($urandom);
        case ($urandom_range(3))
            0: ;
            1: p.ring = ANG_W'($urandom_range(32768) - 16384);
            2: begin
                p.ring = angle_near_split();
                p.sector = angle_near_split();
                p.radius = RAD_W'(RADIUS_MAX - $urandom_range(255));
            end
            default: p.radius = RAD_W'($urandom_range(4095));
        endcase
        return p;
    endfunction

    function automatic t_point make_point(int ring, int sector, int radius);
        t_point p;
        p.ring = ANG_W'(ring);
        p.sector = ANG_W'(sector);
        p.radius = RAD_W'(radius);
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    // also waits for a transaction still held on the input
    task automatic drain_all();
        while (pending_points.size() != 0 || expected_xyz.size() != 0 || pt_if.valid)
            @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // sender
    always @(posedge i_clk) begin : drive_points
        t_point p;
        if (!i_rst_n) begin
            pt_if.valid <= 1'b0;
        end else begin
            if (pt_if.valid && pt_if.ready) begin
                p.ring = pt_if.ring_fraction;
                p.sector = pt_if.sector_fraction;
                p.radius = pt_if.radius;
                expected_xyz.push_back(predict_xyz(p));
                points_sent++;
            end
            if (!pt_if.valid || pt_if.ready) begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    p = pending_points.pop_front();
                    pt_if.valid <= 1'b1;
                    pt_if.ring_fraction <= p.ring;
                    pt_if.sector_fraction <= p.sector;
                    pt_if.radius <= p.radius;
                end else begin
                    pt_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            xyz_if.ready <= 1'b0;
        else
            xyz_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_xyz want;
        if (i_rst_n && xyz_if.valid && xyz_if.ready) begin
            if (expected_xyz.size() == 0) begin
                report_mismatch($sformatf("result with no point pending x=%0d y=%0d z=%0d",
                                          xyz_if.x_coord, xyz_if.y_coord, xyz_if.z_coord));
            end else begin
                want = expected_xyz.pop_front();
                if (xyz_if.x_coord !== want.x)
                    report_mismatch($sformatf("result %0d x got %0d want %0d",
                                              results_checked, xyz_if.x_coord, want.x));
                if (xyz_if.y_coord !== want.y)
                    report_mismatch($sformatf("result %0d y got %0d want %0d",
                                              results_checked, xyz_if.y_coord, want.y));
                if (xyz_if.z_coord !== want.z)
                    report_mismatch($sformatf("result %0d z got %0d want %0d",
                                              results_checked, xyz_if.z_coord, want.z));
            end
            results_checked++;
        end
    end

    // no transaction on either side for too long means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((pt_if.valid && pt_if.ready) || (xyz_if.valid && xyz_if.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("no transaction for %0d cycles, %0d results outstanding",
                         stall_cycles, expected_xyz.size());
                $display("spherical_to_cartesian test failed");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        pt_if.valid = 1'b0;
        pt_if.ring_fraction = '0;
        pt_if.sector_fraction = '0;
        pt_if.radius = '0;
        xyz_if.ready = 1'b0;
        i_rst_n = 1'b0;
        points_sent = 0;
        results_checked = 0;
        mismatch_count = 0;
        stall_cycles = 0;
        send_idle_pct = 17;
        recv_idle_pct = 78;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners: poles, quadrant splits, wrapped ring, radius extremes
        pending_points.push_back(make_point(0, 0, 0));
        pending_points.push_back(make_point(0, 0, RADIUS_MAX));
        pending_points.push_back(make_point(16384, 0, RADIUS_MAX));
        pending_points.push_back(make_point(-16384, 0, RADIUS_MAX));
        pending_points.push_back(make_point(0, 16384, RADIUS_MAX));
        pending_points.push_back(make_point(0, 32768, RADIUS_MAX));
        pending_points.push_back(make_point(0, 49152, RADIUS_MAX));
        pending_points.push_back(make_point(0, 65535, RADIUS_MAX));
        pending_points.push_back(make_point(32767, 12345, 256));
        pending_points.push_back(make_point(-32768, 54321, 256));
        pending_points.push_back(make_point(8192, 8192, 256));
        pending_points.push_back(make_point(8191, 8191, 256));
        pending_points.push_back(make_point(-8192, 24576, 256));
        pending_points.push_back(make_point(-8193, 24575, 256));
        pending_points.push_back(make_point(4096, 40960, 1));
        pending_points.push_back(make_point(-1, 1, 1));
        pending_points.push_back(make_point(16383, 65534, 24'h800000));
        pending_points.push_back(make_point(-16383, 2, 24'h7FFFFF));
        pending_points.push_back(make_point(16384, 16384, 24'hAAAAAA));
        pending_points.push_back(make_point(-16384, 43690, 24'h555555));
        // wait until every directed point is sent and its result checked
        drain_all();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 17; recv_idle_pct = 78; end
                1: begin send_idle_pct = 78; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                pending_points.push_back(random_point());
            drain_all();
        end

        repeat (PIPE_LATENCY + 8) @(posedge i_clk);
        $display("sent %0d points and checked %0d results over three backpressure phases",
                 points_sent, results_checked);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0) begin
            $display("spherical_to_cartesian test passed");
        end else begin
            $display("spherical_to_cartesian test failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/s2c_pkg.sv
rtl/core/s2c_if.sv
rtl/core/s2c_angle.sv
rtl/core/s2c_cordic.sv
rtl/core/s2c_scale.sv
rtl/core/spherical_to_cartesian.sv
rtl/core/s2c_check.sv
sim/spherical_to_cartesian_tb.sv
